[hdl/sts_pkg.sv]
// Shared types and constants for the Taylor-series sine block.
// Fixed-point constants, reciprocal factorial table, queue item and status types.
// No dependencies.
`default_nettype none

package sts_pkg;

  // Q8.56 angle constants
  localparam logic [63:0] PI_Q56         = 64'h03243F6A8885A309;
  localparam logic [63:0] HALF_PI_Q56    = PI_Q56 >> 1;
  localparam logic [63:0] THREE_HALF_Q56 = PI_Q56 + HALF_PI_Q56;
  localparam logic [63:0] TWO_PI_Q56     = PI_Q56 << 1;

  localparam logic [30:0] ONE_Q30 = 31'h40000000;

  // quotient of |angle| / 2pi is at most 20, so five restoring steps
  localparam int RED_STEPS = 5;
  localparam int MAX_TERMS = 20;

  // round(2^32 / ((2k)(2k+1))) for k = 1..19, index 0 unused
  localparam logic [29:0] RECIP [MAX_TERMS] = '{
    30'd0,
    30'd715827883, 30'd214748365, 30'd102261126, 30'd59652324,
    30'd39045157,  30'd27531842,  30'd20452225,  30'd15790321,
    30'd12558384,  30'd10226113,  30'd8488078,   30'd7158279,
    30'd6118187,   30'd5289369,   30'd4618244,   30'd4067204,
    30'd3609216,   30'd3224450,   30'd2898089
  };

  typedef struct packed {
    logic        neg;
    logic [30:0] t30;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

[hdl/sts_front.sv]
// Front end: accepts angles, takes the magnitude, reduces modulo 2pi and folds
// into [0, pi/2] with a sign, producing queue items. Depends on sts_pkg.
`default_nettype none

module sts_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_angle,
  input  sts_pkg::q_stat_t    q_stat,
  output logic                push,
  output sts_pkg::item_t      push_item
);
  import sts_pkg::*;

  typedef struct packed {
    logic        v;
    logic        neg;
    logic [63:0] x;
  } red_t;

  typedef struct packed {
    logic        v;
    logic        neg;
    logic [56:0] t;
  } fold_t;

  logic   en;
  red_t   s0_r, s0_nxt;
  red_t   rs_r  [RED_STEPS];
  red_t   rs_nxt[RED_STEPS];
  red_t   red_in[RED_STEPS];
  fold_t  fd_r, fd_nxt;
  logic   tv_r;
  item_t  ti_r, ti_nxt;

  assign en        = !(tv_r && q_stat.full);
  assign in_stall  = !en;
  assign push      = tv_r && !q_stat.full;
  assign push_item = ti_r;

  always_comb begin
    logic [31:0] mag;
    mag        = in_angle[31] ? (~in_angle + 32'd1) : in_angle;
    s0_nxt.v   = in_valid;
    s0_nxt.neg = in_angle[31];
    s0_nxt.x   = {mag, 32'b0};
  end

  assign red_in[0] = s0_r;

  for (genvar i = 0; i < RED_STEPS; i++) begin : g_red
    localparam logic [63:0] DIV = TWO_PI_Q56 << (RED_STEPS - 1 - i);
    if (i > 0) begin : g_link
      assign red_in[i] = rs_r[i-1];
    end
    always_comb begin
      rs_nxt[i]   = red_in[i];
      if (red_in[i].x >= DIV) begin
        rs_nxt[i].x = red_in[i].x - DIV;
      end
    end
  end

  always_comb begin
    logic [63:0] r;
    logic [63:0] t;
    r          = rs_r[RED_STEPS-1].x;
    fd_nxt.v   = rs_r[RED_STEPS-1].v;
    fd_nxt.neg = rs_r[RED_STEPS-1].neg;
    if (r < HALF_PI_Q56) begin
      t = r;
    end else if (r < PI_Q56) begin
      t = PI_Q56 - r;
    end else if (r < THREE_HALF_Q56) begin
      t          = r - PI_Q56;
      fd_nxt.neg = !rs_r[RED_STEPS-1].neg;
    end else begin
      t          = TWO_PI_Q56 - r;
      fd_nxt.neg = !rs_r[RED_STEPS-1].neg;
    end
    fd_nxt.t = t[56:0];
  end

  always_comb begin
    logic [56:0] s;
    s          = fd_r.t + 57'd33554432;
    ti_nxt.neg = fd_r.neg;
    ti_nxt.t30 = s[56:26];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.v <= 1'b0;
      fd_r.v <= 1'b0;
      tv_r   <= 1'b0;
      for (int i = 0; i < RED_STEPS; i++) begin
        rs_r[i].v <= 1'b0;
      end
    end else if (en) begin
      s0_r <= s0_nxt;
      fd_r <= fd_nxt;
      tv_r <= fd_r.v;
      ti_r <= ti_nxt;
      for (int i = 0; i < RED_STEPS; i++) begin
        rs_r[i] <= rs_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

[hdl/sts_queue.sv]
// Short request queue between front and back ends.
// Register-based FIFO with a fill count. Depends on sts_pkg.
`default_nettype none

module sts_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sts_pkg::item_t   push_item,
  input  logic             pop,
  output sts_pkg::item_t   pop_item,
  output sts_pkg::q_stat_t q_stat
);
  import sts_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;

  assign pop_item     = mem_r[rptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/sts_back.sv]
// Back end: Horner evaluation of the odd Taylor series, one term per two stages,
// then final product, saturation and sign. Depends on sts_pkg.
`default_nettype none

module sts_back #(
  parameter int TERMS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sts_pkg::q_stat_t   q_stat,
  input  sts_pkg::item_t     pop_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sine
);
  import sts_pkg::*;

  localparam int NT    = (TERMS > MAX_TERMS) ? MAX_TERMS : ((TERMS < 2) ? 2 : TERMS);
  localparam int NSTEP = NT - 1;

  typedef struct packed {
    logic        v;
    logic        neg;
    logic [30:0] t30;
    logic [31:0] t2;
    logic [62:0] m;
  } stg_t;

  function automatic logic [32:0] rnd30(input logic [62:0] m);
    logic [63:0] s;
    s = {1'b0, m} + 64'd536870912;
    return s[62:30];
  endfunction

  function automatic logic [31:0] rnd32(input logic [62:0] m);
    logic [63:0] s;
    s = {1'b0, m} + 64'h80000000;
    return s[63:32];
  endfunction

  function automatic logic [30:0] horner_p(input logic [62:0] m);
    logic [31:0] sub;
    sub = rnd32(m);
    return (sub >= 32'(ONE_Q30)) ? 31'd0 : ONE_Q30 - sub[30:0];
  endfunction

  logic        en;
  stg_t        x0_r, x0_nxt;
  stg_t        a_r  [NSTEP];
  stg_t        a_nxt[NSTEP];
  stg_t        b_r  [NSTEP];
  stg_t        b_nxt[NSTEP];
  stg_t        f_r, f_nxt;
  logic        ov_r;
  logic [31:0] os_r, os_nxt;

  assign en        = !(ov_r && out_stall);
  assign pop       = en && !q_stat.empty;
  assign out_valid = ov_r;
  assign out_sine  = os_r;

  always_comb begin
    x0_nxt.v   = !q_stat.empty;
    x0_nxt.neg = pop_item.neg;
    x0_nxt.t30 = pop_item.t30;
    x0_nxt.t2  = '0;
    x0_nxt.m   = 63'(pop_item.t30) * 63'(pop_item.t30);
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_term
    localparam int          K  = NT - 1 - j;
    localparam logic [29:0] RC = RECIP[K];
    if (j == 0) begin : g_first
      always_comb begin
        logic [32:0] sq;
        sq          = rnd30(x0_r.m);
        a_nxt[j]    = x0_r;
        a_nxt[j].t2 = sq[31:0];
        a_nxt[j].m  = {1'b0, sq[31:0], 30'b0};
      end
    end else begin : g_next
      always_comb begin
        a_nxt[j]   = b_r[j-1];
        a_nxt[j].m = 63'(horner_p(b_r[j-1].m)) * 63'(b_r[j-1].t2);
      end
    end
    always_comb begin
      b_nxt[j]   = a_r[j];
      b_nxt[j].m = 63'(rnd30(a_r[j].m)) * 63'(RC);
    end
  end

  always_comb begin
    f_nxt   = b_r[NSTEP-1];
    f_nxt.m = 63'(b_r[NSTEP-1].t30) * 63'(horner_p(b_r[NSTEP-1].m));
  end

  always_comb begin
    logic [32:0] s;
    logic [31:0] mag;
    s      = rnd30(f_r.m);
    mag    = (s > 33'(ONE_Q30)) ? 32'(ONE_Q30) : s[31:0];
    os_nxt = f_r.neg ? (~mag + 32'd1) : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r.v <= 1'b0;
      f_r.v  <= 1'b0;
      ov_r   <= 1'b0;
      for (int j = 0; j < NSTEP; j++) begin
        a_r[j].v <= 1'b0;
        b_r[j].v <= 1'b0;
      end
    end else if (en) begin
      x0_r <= x0_nxt;
      f_r  <= f_nxt;
      ov_r <= f_r.v;
      os_r <= os_nxt;
      for (int j = 0; j < NSTEP; j++) begin
        a_r[j] <= a_nxt[j];
        b_r[j] <= b_nxt[j];
      end
    end
  end

endmodule

`default_nettype wire

[hdl/sine_taylor_series.sv]
// Top level of the Taylor-series sine block: front end, request queue, back end.
// Depends on sts_pkg, sts_front, sts_queue, sts_back.
//
//   channel  | ports                          | format
//   ---------+--------------------------------+----------------------------
//   input    | in_valid, in_stall, in_angle   | angle, signed Q7.24
//   output   | out_valid, out_stall, out_sine | sine, signed Q1.30, sat +-1
//
// One request per cycle sustained while out_stall is low. Requests pass through 8
// front stages, the queue and 2*TERMS+1 back stages (TERMS clamped to 2..20).
// Reset clears all valid bits and the queue count; no datapath is cleared.
// out_stall freezes the back end while out_valid is high; in_stall rises when
// the queue is full and the front end's last stage holds a request.
`default_nettype none

module sine_taylor_series #(
  parameter int TERMS       = 20,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sine
);
  import sts_pkg::*;

  q_stat_t q_stat;
  item_t   push_item, pop_item;
  logic    push, pop;

  sts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_angle  (in_angle),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  sts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  sts_back #(
    .TERMS (TERMS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_sine  (out_sine)
  );

endmodule

`default_nettype wire
